### rtl/nsfp_pkg.sv
// Package for the near-square factor pair block: widths, state type, unit status.
`default_nettype none
package nsfp_pkg;

   localparam int AREA_BITS_DEF = 24;
   localparam int LENGTH_BITS   = 24;
   localparam int WIDTH_BITS    = 13;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROOT,
      ST_DIV,
      ST_DONE
   } state_type;

   // status of a multi-cycle arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage
`default_nettype wire

### rtl/near_square_factor_pair.sv
// Top level of the near-square factor pair block: sequencer and result register.
//
//   channel  ports                              direction
//   req      req_valid req_ready req_area       in
//   rsp      rsp_valid rsp_ready rsp_length/width  out
//
// Root: the serial square root unit computes the floor root R of the area.
// Each candidate is tested in the serial divider; candidates run from the
// root downward, so the time an item takes grows with the number of
// candidates tested, and is longest for a prime area.
// Reset clears the sequencer and the result valid; no clearing pass.
// A new area is taken while the previous result still waits on rsp; a held
// rsp stalls only the hand-off of the next finished result.
`default_nettype none
module near_square_factor_pair
   import nsfp_pkg::*;
#(
   parameter  int AREA_BITS = AREA_BITS_DEF,
   localparam int ROOT_BITS = (AREA_BITS + 1) / 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [AREA_BITS-1:0]   req_area,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic      [LENGTH_BITS-1:0] rsp_length,
   output logic      [WIDTH_BITS-1:0]  rsp_width
);

   state_type state_ff, state_in;

   logic [AREA_BITS-1:0]   area_ff;
   logic [ROOT_BITS-1:0]   cand_ff;
   logic [ROOT_BITS-1:0]   cand_in;
   logic [LENGTH_BITS-1:0] res_len_ff;
   logic [WIDTH_BITS-1:0]  res_w_ff;
   logic                   rsp_valid_ff;
   logic [LENGTH_BITS-1:0] rsp_len_ff;
   logic [WIDTH_BITS-1:0]  rsp_w_ff;

   unit_status_type        root_status;
   unit_status_type        div_status;
   logic [ROOT_BITS-1:0]   root;
   logic [AREA_BITS-1:0]   quotient;
   logic [ROOT_BITS-1:0]   remainder;

   logic                   root_start;
   logic                   div_start;
   logic                   root_zero;
   logic                   found;
   logic                   out_free;

   assign root_zero = (root == '0);
   assign found     = (remainder == '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   nsfp_isqrt #(.AREA_BITS(AREA_BITS)) u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (root_start),
      .value  (req_area),
      .status (root_status),
      .root   (root)
   );

   nsfp_divider #(.AREA_BITS(AREA_BITS), .ROOT_BITS(ROOT_BITS)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (area_ff),
      .divisor   (cand_in),
      .status    (div_status),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_status.done) state_in = root_zero ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done && found) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready  = 1'b0;
      root_start = 1'b0;
      div_start  = 1'b0;
      cand_in    = cand_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            root_start = req_valid;
         end
         ST_ROOT: begin
            cand_in   = root;
            div_start = root_status.done && !root_zero;
         end
         ST_DIV: begin
            // candidate 1 always divides, so the scan ends
            cand_in   = cand_ff - 1'b1;
            div_start = div_status.done && !found;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (root_start) area_ff <= req_area;
      if (div_start)  cand_ff <= cand_in;
      if (state_ff == ST_ROOT && root_status.done && root_zero) begin
         res_len_ff <= '0;
         res_w_ff   <= WIDTH_BITS'(1);
      end else if (state_ff == ST_DIV && div_status.done && found) begin
         res_len_ff <= LENGTH_BITS'(quotient);
         res_w_ff   <= WIDTH_BITS'(cand_ff);
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_len_ff <= res_len_ff;
         rsp_w_ff   <= res_w_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_length = rsp_len_ff;
   assign rsp_width  = rsp_w_ff;

endmodule
`default_nettype wire

### rtl/nsfp_isqrt.sv
// Bit-serial floor square root: one root bit (two area bits) per cycle.
`default_nettype none
module nsfp_isqrt
   import nsfp_pkg::*;
#(
   parameter  int AREA_BITS = AREA_BITS_DEF,
   localparam int ROOT_BITS = (AREA_BITS + 1) / 2,
   localparam int CNT_BITS  = $clog2(ROOT_BITS + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [AREA_BITS-1:0] value,
   output unit_status_type           status,
   output logic      [ROOT_BITS-1:0] root
);

   logic                   busy_ff;
   logic                   done_ff;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic [2*ROOT_BITS-1:0] x_ff;
   logic [ROOT_BITS+1:0]   rem_ff;
   logic [ROOT_BITS-1:0]   root_ff;

   logic [ROOT_BITS+3:0]   rem_t;
   logic [ROOT_BITS+3:0]   trial;
   logic [ROOT_BITS+3:0]   diff;
   logic                   fits;
   logic [ROOT_BITS+1:0]   rem_in;
   logic [ROOT_BITS:0]     root_in;

   always_comb begin
      rem_t   = {rem_ff, x_ff[2*ROOT_BITS-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      fits    = (rem_t >= trial);
      diff    = rem_t - trial;
      // remainder never exceeds twice the root, so the top bits are zero
      rem_in  = fits ? diff[ROOT_BITS+1:0] : rem_t[ROOT_BITS+1:0];
      root_in = {root_ff, fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(ROOT_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= (2*ROOT_BITS)'(value);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         x_ff    <= x_ff << 2;
         rem_ff  <= rem_in;
         root_ff <= root_in[ROOT_BITS-1:0];
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule
`default_nettype wire

### rtl/nsfp_divider.sv
// Restoring bit-serial divider: one quotient bit per cycle.
`default_nettype none
module nsfp_divider
   import nsfp_pkg::*;
#(
   parameter  int AREA_BITS = AREA_BITS_DEF,
   parameter  int ROOT_BITS = (AREA_BITS + 1) / 2,
   localparam int CNT_BITS  = $clog2(AREA_BITS + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [AREA_BITS-1:0] dividend,
   input  wire logic [ROOT_BITS-1:0] divisor,
   output unit_status_type           status,
   output logic      [AREA_BITS-1:0] quotient,
   output logic      [ROOT_BITS-1:0] remainder
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic [AREA_BITS-1:0] q_ff;
   logic [ROOT_BITS-1:0] r_ff;
   logic [ROOT_BITS-1:0] d_ff;

   logic [ROOT_BITS:0]   partial;
   logic [ROOT_BITS:0]   diff;
   logic                 fits;
   logic [ROOT_BITS-1:0] r_in;
   logic [AREA_BITS-1:0] q_in;

   always_comb begin
      partial = {r_ff, q_ff[AREA_BITS-1]};
      fits    = (partial >= {1'b0, d_ff});
      diff    = partial - {1'b0, d_ff};
      r_in    = fits ? diff[ROOT_BITS-1:0] : partial[ROOT_BITS-1:0];
      // dividend bits leave at the top while quotient bits enter at the bottom
      q_in    = {q_ff[AREA_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(AREA_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= dividend;
         r_ff <= '0;
         d_ff <= divisor;
      end else if (busy_ff) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff;
   assign remainder   = r_ff;

endmodule
`default_nettype wire

### verif/tb_top.sv
// Testbench for near_square_factor_pair: directed and random areas against a local predictor.
`default_nettype none
module tb_top;
   import nsfp_pkg::*;

   localparam int AREA_BITS    = AREA_BITS_DEF;
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam int PHASE_ITEMS  = 25;

   typedef struct {
      logic [LENGTH_BITS-1:0] length;
      logic [WIDTH_BITS-1:0]  width;
   } factor_pair_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [AREA_BITS-1:0]   req_area  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [LENGTH_BITS-1:0] rsp_length;
   logic [WIDTH_BITS-1:0]  rsp_width;

   factor_pair_type pending_pairs[$];
   int              send_idle_pct = 0;
   int              rsp_stall_pct = 0;
   int              areas_sent    = 0;
   int              pairs_checked = 0;
   int              error_count   = 0;
   int              cycle_count   = 0;
   int              widest_pair   = 0;

   near_square_factor_pair dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_area   (req_area),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_length (rsp_length),
      .rsp_width  (rsp_width)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Largest divisor not above the floor root, found by scanning down from the root.
   function automatic factor_pair_type nearest_factor_pair(logic [AREA_BITS-1:0] area);
      longint unsigned a;
      longint unsigned root;
      longint unsigned trial;
      longint unsigned cand;
      factor_pair_type pair;
      a    = 64'(area);
      root = 0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= a)
            root = trial;
      end
      pair.width  = WIDTH_BITS'(1);
      pair.length = '0;
      if (a != 0) begin
         for (cand = root; cand > 0; cand--) begin
            if (a % cand == 0) begin
               pair.width = WIDTH_BITS'(cand);
               break;
            end
         end
         pair.length = LENGTH_BITS'(a / cand);
      end
      return pair;
   endfunction

   // Mostly small areas and near-square products so the scan stays short.
   function automatic logic [AREA_BITS-1:0] random_area();
      int          kind;
      int unsigned lo;
      int unsigned hi;
      kind = $urandom_range(0, 99);
      if (kind < 40)
         return AREA_BITS'($urandom_range(0, 4095));
      lo = $urandom_range(1, 4000);
      hi = lo + $urandom_range(0, 90);
      return AREA_BITS'(lo * hi);
   endfunction

   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("near_square_factor_pair: mismatch");
         $finish;
      end
   end

   // Result check first, then record the area accepted at the same edge.
   always @(posedge clock) begin
      factor_pair_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_pairs.size() == 0) begin
               $error("unexpected result: length %0d width %0d", rsp_length, rsp_width);
               error_count++;
            end else begin
               want = pending_pairs.pop_front();
               pairs_checked++;
               if (rsp_length !== want.length) begin
                  $error("length: expected %0d, got %0d", want.length, rsp_length);
                  error_count++;
               end
               if (rsp_width !== want.width) begin
                  $error("width: expected %0d, got %0d", want.width, rsp_width);
                  error_count++;
               end
               if (int'(rsp_width) > widest_pair)
                  widest_pair = int'(rsp_width);
            end
         end
         if (req_valid && req_ready)
            pending_pairs.push_back(nearest_factor_pair(req_area));
      end
   end

   task automatic send_area(input logic [AREA_BITS-1:0] area);
      @(negedge clock);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(negedge clock);
         while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_area  <= area;
      do
         @(posedge clock);
      while (!req_ready);
      areas_sent++;
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      // one unrestricted area per phase; it may need the full scan
      send_area(AREA_BITS'($urandom_range(0, 24'hFFFFFF)));
      repeat (PHASE_ITEMS - 1)
         send_area(random_area());
   endtask

   task automatic test_directed();
      logic [AREA_BITS-1:0] areas[$];
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      areas = '{
         24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd6, 24'd7, 24'd8, 24'd9, 24'd12,
         24'd65521,                 // prime, short scan
         24'd65536,
         24'd8388608,               // top bit alone
         24'd16769025,              // 4095 squared
         24'd16773120,              // 4095 x 4096
         24'd16777215,              // all ones
         24'd16777213,              // largest prime that fits: full scan
         24'hAAAAAA, 24'h555555
      };
      foreach (areas[i])
         send_area(areas[i]);
   endtask

   task automatic test_no_idle();
      run_random_phase(0, 0);
   endtask

   task automatic test_sender_idle();
      run_random_phase(75, 0);
   endtask

   task automatic test_receiver_stall();
      run_random_phase(0, 75);
   endtask

   task automatic test_both_idle();
      run_random_phase(24, 24);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_no_idle();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      drain_results();
      $display("%0d areas sent (edges, primes, near-square products), %0d pairs checked",
               areas_sent, pairs_checked);
      $display("idle: none, sender 75%%, receiver 75%%, both 24%%; widest %0d, %0d cycles",
               widest_pair, cycle_count);
      if (error_count == 0)
         $display("near_square_factor_pair: match");
      else
         $display("near_square_factor_pair: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
